// ===== design/tsms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsms_pkg
// Types and constants for the timestamp to milliseconds unit.
// ----------------------------------------------------------------------------
package tsms_pkg;

  localparam int unsigned MillisWidth = 29;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } char_item_t;

  typedef struct packed {
    logic                   ok;
    logic [MillisWidth-1:0] millis;
  } result_item_t;

  typedef enum logic [3:0] {
    POS_MS_UNITS   = 4'd0,
    POS_MS_TENS    = 4'd1,
    POS_MS_HUNDS   = 4'd2,
    POS_MS_DOT     = 4'd3,
    POS_SEC_UNITS  = 4'd4,
    POS_SEC_TENS   = 4'd5,
    POS_SEC_COLON  = 4'd6,
    POS_MIN_UNITS  = 4'd7,
    POS_MIN_TENS   = 4'd8,
    POS_MIN_COLON  = 4'd9,
    POS_HOUR_UNITS = 4'd10,
    POS_HOUR_TENS  = 4'd11,
    POS_END        = 4'd12
  } pos_t;

  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharFive  = 8'h35;  // '5'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharColon = 8'h3A;  // ':'
  localparam logic [7:0] CharDot   = 8'h2E;  // '.'

  localparam logic [MillisWidth-1:0] WeightMsTens    = MillisWidth'(10);
  localparam logic [MillisWidth-1:0] WeightMsHunds   = MillisWidth'(100);
  localparam logic [MillisWidth-1:0] WeightSecUnits  = MillisWidth'(1000);
  localparam logic [MillisWidth-1:0] WeightSecTens   = MillisWidth'(10 * 1000);
  localparam logic [MillisWidth-1:0] WeightMinUnits  = MillisWidth'(60 * 1000);
  localparam logic [MillisWidth-1:0] WeightMinTens   = MillisWidth'(10 * 60 * 1000);
  localparam logic [MillisWidth-1:0] WeightHourUnits = MillisWidth'(60 * 60 * 1000);
  localparam logic [MillisWidth-1:0] WeightHourTens  = MillisWidth'(10 * 60 * 60 * 1000);
  localparam logic [MillisWidth-1:0] WeightMsUnits   = MillisWidth'(1);

endpackage

// ===== design/timestamp_to_milliseconds_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_milliseconds_unit
// Parses an h:mm:ss.mmm timestamp fed last character first into milliseconds.
// ----------------------------------------------------------------------------
// One character item is taken per cycle while char_stall is low. Each item
// is captured in an input register, then checked and weighted against the
// current position combinationally (one constant-weight add into the running
// total); the item that carries final_char then loads the result register,
// which holds its result item, once the result slot is free. The input side
// stalls only while a result waits on a stalled output and another final
// character is ready behind it.
// Any bad character makes ok low and millis zero; the parser state returns
// to the start after every final character.
module timestamp_to_milliseconds_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  tsms_pkg::char_item_t      char_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output tsms_pkg::result_item_t    result_item
);

  logic                               in_valid;
  tsms_pkg::char_item_t               in_item;
  logic                               step;

  tsms_pkg::pos_t                     position;
  tsms_pkg::pos_t                     position_next;
  logic [tsms_pkg::MillisWidth-1:0]   total;
  logic [tsms_pkg::MillisWidth-1:0]   total_next;
  logic                               failed;
  logic                               failed_next;

  logic [7:0]                         c;
  logic                               is_dig9;
  logic                               is_dig5;
  logic [3:0]                         digit;
  logic                               add_en;
  logic [tsms_pkg::MillisWidth-1:0]   weight;
  logic [tsms_pkg::MillisWidth-1:0]   add_term;
  logic                               bad;
  tsms_pkg::pos_t                     pos_adv;

  // a non-final item never needs the result slot
  assign step = in_valid &&
                (!in_item.final_char || !result_valid || !result_stall);
  assign char_stall = in_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || step) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_item <= char_item;
    end
  end

  assign c       = in_item.char_code;
  assign is_dig9 = (c >= tsms_pkg::CharZero) && (c <= tsms_pkg::CharNine);
  assign is_dig5 = (c >= tsms_pkg::CharZero) && (c <= tsms_pkg::CharFive);
  assign digit   = c[3:0];

  always_comb begin
    pos_adv = position;
    add_en  = 1'b0;
    weight  = tsms_pkg::WeightMsUnits;
    bad     = 1'b0;
    unique case (position)
      tsms_pkg::POS_MS_UNITS: begin
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_MS_TENS;
        end else bad = 1'b1;
      end
      tsms_pkg::POS_MS_TENS: begin
        weight = tsms_pkg::WeightMsTens;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_MS_HUNDS;
        end else if (c == tsms_pkg::CharDot) pos_adv = tsms_pkg::POS_SEC_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_MS_HUNDS: begin
        weight = tsms_pkg::WeightMsHunds;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_MS_DOT;
        end else if (c == tsms_pkg::CharDot) pos_adv = tsms_pkg::POS_SEC_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_MS_DOT: begin
        if (c == tsms_pkg::CharDot) pos_adv = tsms_pkg::POS_SEC_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_SEC_UNITS: begin
        weight = tsms_pkg::WeightSecUnits;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_SEC_TENS;
        end else bad = 1'b1;
      end
      tsms_pkg::POS_SEC_TENS: begin
        weight = tsms_pkg::WeightSecTens;
        if (is_dig5) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_SEC_COLON;
        end else if (c == tsms_pkg::CharColon) pos_adv = tsms_pkg::POS_MIN_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_SEC_COLON: begin
        if (c == tsms_pkg::CharColon) pos_adv = tsms_pkg::POS_MIN_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_MIN_UNITS: begin
        weight = tsms_pkg::WeightMinUnits;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_MIN_TENS;
        end else bad = 1'b1;
      end
      tsms_pkg::POS_MIN_TENS: begin
        weight = tsms_pkg::WeightMinTens;
        if (is_dig5) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_MIN_COLON;
        end else if (c == tsms_pkg::CharColon) pos_adv = tsms_pkg::POS_HOUR_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_MIN_COLON: begin
        if (c == tsms_pkg::CharColon) pos_adv = tsms_pkg::POS_HOUR_UNITS;
        else bad = 1'b1;
      end
      tsms_pkg::POS_HOUR_UNITS: begin
        weight = tsms_pkg::WeightHourUnits;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_HOUR_TENS;
        end else bad = 1'b1;
      end
      tsms_pkg::POS_HOUR_TENS: begin
        weight = tsms_pkg::WeightHourTens;
        if (is_dig9) begin
          add_en = 1'b1; pos_adv = tsms_pkg::POS_END;
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
  end

  assign add_term = add_en ?
      tsms_pkg::MillisWidth'(weight * {{(tsms_pkg::MillisWidth-4){1'b0}}, digit}) : '0;

  always_comb begin
    position_next = position;
    total_next    = total;
    failed_next   = failed;
    if (!failed) begin
      position_next = pos_adv;
      total_next    = total + add_term;
      failed_next   = bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= tsms_pkg::POS_MS_UNITS;
      total    <= '0;
      failed   <= 1'b0;
    end else if (step) begin
      if (in_item.final_char) begin
        position <= tsms_pkg::POS_MS_UNITS;
        total    <= '0;
        failed   <= 1'b0;
      end else begin
        position <= position_next;
        total    <= total_next;
        failed   <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && in_item.final_char) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_item.final_char) begin
      result_item.ok     <= !failed_next;
      result_item.millis <= failed_next ? '0 : total_next;
    end
  end

  a_restart_after_final: assert property (@(posedge clk) disable iff (rst)
    step && in_item.final_char |=>
      position == tsms_pkg::POS_MS_UNITS && total == '0 && !failed)
    else $error("parser state not cleared after final item");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && step && !in_item.final_char |=> failed)
    else $error("failure flag dropped inside a timestamp");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step && in_item.final_char))
    else $error("result raised without a final item");

  a_bad_result_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.ok |-> result_item.millis == '0)
    else $error("failed result carries a nonzero total");

endmodule
